// ===== hw/rtl/slc_deframer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_deframer_pkg
// Shared types and constants for the sync/length/sum16 deframer.
// ----------------------------------------------------------------------------
package slc_deframer_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;
	localparam int IDX_W  = 2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_TYPE,
		PH_LENHI,
		PH_LENLO,
		PH_DATA,
		PH_SUMHI,
		PH_SUMLO
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BADSUM,
		ST_LONG
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SYNC_FIRST,
		REG_SYNC_SECOND,
		REG_MAX_LENGTH
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [LEN_W-1:0]  max_length;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] ftype;
		logic              last;
		status_t           status;
	} result_t;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 16'd256;

endpackage

// ===== hw/rtl/slc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_cfg
// Configuration register file: sync bytes and maximum payload length.
// ----------------------------------------------------------------------------
module slc_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [slc_deframer_pkg::IDX_W-1:0]     wr_index,
	input  logic [slc_deframer_pkg::LEN_W-1:0]     wr_data,
	output slc_deframer_pkg::cfg_t                 cfg
);
	import slc_deframer_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.max_length  <= MAX_LENGTH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SYNC_FIRST:  cfg_q.sync_first  <= wr_data[BYTE_W-1:0];
				REG_SYNC_SECOND: cfg_q.sync_second <= wr_data[BYTE_W-1:0];
				REG_MAX_LENGTH:  cfg_q.max_length  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/slc_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_fsm
// Frame phase tracker: sync hunt, header capture, payload sum and check.
// ----------------------------------------------------------------------------
module slc_fsm (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   step,
	input  logic [slc_deframer_pkg::BYTE_W-1:0]    rx_byte,
	input  slc_deframer_pkg::cfg_t                 cfg,
	output slc_deframer_pkg::result_t              res
);
	import slc_deframer_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  seen_q, seen_d;
	logic [LEN_W-1:0]  sum_q, sum_d;
	logic [BYTE_W-1:0] sumhi_q, sumhi_d;
	logic [LEN_W-1:0]  len_full;
	logic [LEN_W-1:0]  seen_inc;
	logic [LEN_W-1:0]  sum_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			type_q  <= '0;
			len_q   <= '0;
			seen_q  <= '0;
			sum_q   <= '0;
			sumhi_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			sum_q   <= sum_d;
			sumhi_q <= sumhi_d;
		end
	end

	assign len_full = {len_q[LEN_W-1:BYTE_W], rx_byte};
	assign seen_inc = seen_q + LEN_W'(1);
	assign sum_inc  = sum_q + {{(LEN_W-BYTE_W){1'b0}}, rx_byte};

	always_comb begin
		phase_d    = phase_q;
		type_d     = type_q;
		len_d      = len_q;
		seen_d     = seen_q;
		sum_d      = sum_q;
		sumhi_d    = sumhi_q;
		res.valid  = 1'b0;
		res.data   = '0;
		res.ftype  = type_q;
		res.last   = 1'b0;
		res.status = ST_OK;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.sync_first)
					phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == cfg.sync_second) ? PH_TYPE : PH_HUNT;
			end
			PH_TYPE: begin
				type_d  = rx_byte;
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				len_d   = {rx_byte, {BYTE_W{1'b0}}};
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				len_d  = len_full;
				sum_d  = '0;
				seen_d = '0;
				if (len_full > cfg.max_length) begin
					phase_d    = PH_HUNT;
					res.valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_LONG;
				end else begin
					phase_d = (len_full == '0) ? PH_SUMHI : PH_DATA;
				end
			end
			PH_DATA: begin
				sum_d     = sum_inc;
				seen_d    = seen_inc;
				if (seen_inc >= len_q)
					phase_d = PH_SUMHI;
				res.valid = 1'b1;
				res.data  = rx_byte;
			end
			PH_SUMHI: begin
				sumhi_d = rx_byte;
				phase_d = PH_SUMLO;
			end
			PH_SUMLO: begin
				phase_d    = PH_HUNT;
				res.valid  = 1'b1;
				res.last   = 1'b1;
				res.status = ({sumhi_q, rx_byte} == sum_q) ? ST_OK : ST_BADSUM;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

endmodule

// ===== hw/rtl/sync_length_checksum_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Byte-stream deframer: sync pair, type, 16-bit length, payload, sum16 check.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock cycle while in_stall is low and delivers
// each payload byte with its frame type, plus one end-of-frame status
// request per frame (ok, bad checksum, or length above max_length). A byte
// passes through an input register, the phase/sum update logic and an
// output register that drives out_valid; the result is taken in a cycle
// with out_stall low. Throughput is one byte per cycle while the output is
// not held. A held output stalls the input only once the input register is
// also full. Configuration writes take effect on the next cycle and are
// meant to be issued while the block is idle.
module sync_length_checksum_deframer_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [slc_deframer_pkg::IDX_W-1:0]     wr_index,
	input  logic [slc_deframer_pkg::LEN_W-1:0]     wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [slc_deframer_pkg::BYTE_W-1:0]    in_byte,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [slc_deframer_pkg::BYTE_W-1:0]    payload_byte,
	output logic [slc_deframer_pkg::BYTE_W-1:0]    frame_type,
	output logic                                   frame_end,
	output logic [1:0]                             frame_status
);
	import slc_deframer_pkg::*;

	cfg_t              cfg;
	result_t           res;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              accept;
	logic              advance;
	logic              out_valid_q;
	logic [BYTE_W-1:0] data_q;
	logic [BYTE_W-1:0] ftype_q;
	logic              last_q;
	status_t           status_q;

	slc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	slc_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= in_byte;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			data_q   <= res.data;
			ftype_q  <= res.ftype;
			last_q   <= res.last;
			status_q <= res.status;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = data_q;
	assign frame_type   = ftype_q;
	assign frame_end    = last_q;
	assign frame_status = status_q;

endmodule

// ===== hw/rtl/slc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks for the deframer core, bound to the top level.
// ----------------------------------------------------------------------------
module slc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_stall,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] payload_byte,
	input  logic [7:0] frame_type,
	input  logic       frame_end,
	input  logic [1:0] frame_status
);
	import slc_deframer_pkg::*;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(frame_type) && $stable(frame_end) && $stable(frame_status))
		else $error("stalled output request changed");

	a_end_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> payload_byte == '0)
		else $error("end-of-frame request carries payload data");

	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> frame_status == ST_OK)
		else $error("payload request carries nonzero status");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status == ST_OK || frame_status == ST_BADSUM
			|| frame_status == ST_LONG)
		else $error("illegal frame status");

	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

endmodule

bind sync_length_checksum_deframer_core slc_checker u_slc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.payload_byte (payload_byte),
	.frame_type   (frame_type),
	.frame_end    (frame_end),
	.frame_status (frame_status)
);

// ===== test/sync_length_checksum_deframer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core_test
// Self-checking bench for the sync/length/sum16 byte-stream deframer.
// ----------------------------------------------------------------------------
// Feeds directed frames, mid-frame register changes, a long output hold-off
// and random framed, broken and noise traffic under four register settings
// and idling mixes. A deframer kept inside the bench predicts every payload
// request and frame status; the checker compares them in order.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_core_test;
	import slc_deframer_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT   = 100000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_BYTES   = 280;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic [BYTE_W-1:0] byte_queue_t[$];

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] ftype;
		logic              last;
		status_t           status;
	} delivery_t;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [LEN_W-1:0]  wr_data;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] frame_type;
	logic              frame_end;
	logic [1:0]        frame_status;

	cfg_t              shadow_cfg;
	phase_t            frame_phase;
	logic [BYTE_W-1:0] cur_type;
	logic [BYTE_W-1:0] sum_high;
	logic [LEN_W-1:0]  frame_len;
	logic [LEN_W-1:0]  payload_count;
	logic [LEN_W-1:0]  payload_sum;
	delivery_t         expected_deliveries[$];

	int framed_bytes   = 0;
	int payload_total  = 0;
	int ends_ok        = 0;
	int ends_bad       = 0;
	int ends_long      = 0;
	int mismatch_count = 0;
	int idle_pct       = 0;
	int stall_pct      = 0;
	int hold_requests  = 0;
	int holds_served   = 0;

	sync_length_checksum_deframer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.frame_type   (frame_type),
		.frame_end    (frame_end),
		.frame_status (frame_status)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic void push_delivery(logic [BYTE_W-1:0] data, logic last,
			status_t status);
		delivery_t d;
		d.data   = data;
		d.ftype  = cur_type;
		d.last   = last;
		d.status = status;
		expected_deliveries = {expected_deliveries, d};
		if (!last)
			payload_total++;
		else if (status == ST_OK)
			ends_ok++;
		else if (status == ST_BADSUM)
			ends_bad++;
		else
			ends_long++;
	endfunction

	function automatic void deframe_byte(logic [BYTE_W-1:0] b);
		if (frame_phase != PH_HUNT || b == shadow_cfg.sync_first)
			framed_bytes++;
		case (frame_phase)
			PH_HUNT: begin
				if (b == shadow_cfg.sync_first)
					frame_phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (b == shadow_cfg.sync_second)
					frame_phase = PH_TYPE;
				else
					frame_phase = PH_HUNT;
			end
			PH_TYPE: begin
				cur_type    = b;
				frame_phase = PH_LENHI;
			end
			PH_LENHI: begin
				frame_len   = {b, 8'h00};
				frame_phase = PH_LENLO;
			end
			PH_LENLO: begin
				frame_len[7:0] = b;
				payload_sum    = '0;
				payload_count  = '0;
				if (frame_len > shadow_cfg.max_length) begin
					frame_phase = PH_HUNT;
					push_delivery(8'h00, 1'b1, ST_LONG);
				end else if (frame_len == '0) begin
					frame_phase = PH_SUMHI;
				end else begin
					frame_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				payload_sum   = payload_sum + b;
				payload_count = payload_count + 1'b1;
				if (payload_count >= frame_len)
					frame_phase = PH_SUMHI;
				push_delivery(b, 1'b0, ST_OK);
			end
			PH_SUMHI: begin
				sum_high    = b;
				frame_phase = PH_SUMLO;
			end
			default: begin
				frame_phase = PH_HUNT;
				if ({sum_high, b} == payload_sum)
					push_delivery(8'h00, 1'b1, ST_OK);
				else
					push_delivery(8'h00, 1'b1, ST_BADSUM);
			end
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] random_byte_except(logic [BYTE_W-1:0] x);
		logic [BYTE_W-1:0] r;
		do r = BYTE_W'($urandom); while (r == x);
		return r;
	endfunction

	// hold payload until accepted, then maybe idle
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		deframe_byte(b);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_stream(input byte_queue_t s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic wait_idle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_deliveries.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
		wait_idle();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_SYNC_FIRST:  shadow_cfg.sync_first  = value[7:0];
			REG_SYNC_SECOND: shadow_cfg.sync_second = value[7:0];
			REG_MAX_LENGTH:  shadow_cfg.max_length  = value;
			default: ;
		endcase
	endtask

	// upper data bits of the byte registers are junk and must be dropped
	task automatic set_config(input logic [BYTE_W-1:0] sf, input logic [BYTE_W-1:0] ss,
			input logic [LEN_W-1:0] ml);
		logic [BYTE_W-1:0] junk;
		junk = BYTE_W'($urandom);
		write_reg(REG_SYNC_FIRST, {junk, sf});
		junk = BYTE_W'($urandom);
		write_reg(REG_SYNC_SECOND, {junk, ss});
		write_reg(REG_MAX_LENGTH, ml);
	endtask

	task automatic push_header(ref byte_queue_t s, input logic [BYTE_W-1:0] ftype,
			input int len);
		s = {s, shadow_cfg.sync_first};
		s = {s, shadow_cfg.sync_second};
		s = {s, ftype};
		s = {s, len[15:8]};
		s = {s, len[7:0]};
	endtask

	task automatic send_random_frame();
		byte_queue_t       s;
		int                kind;
		int                len;
		int                lim;
		logic [LEN_W-1:0]  sum;
		logic [BYTE_W-1:0] b;
		kind = $urandom_range(99);
		if (kind < 6) begin
			repeat ($urandom_range(6, 1))
				s = {s, random_byte_except(shadow_cfg.sync_first)};
		end else if (kind < 14) begin
			s = {s, shadow_cfg.sync_first};
			if ($urandom_range(1) == 1 && shadow_cfg.sync_first != shadow_cfg.sync_second)
				b = shadow_cfg.sync_first;
			else
				b = random_byte_except(shadow_cfg.sync_second);
			s = {s, b};
		end else if (kind < 26 && shadow_cfg.max_length != 16'hFFFF) begin
			b   = BYTE_W'($urandom);
			len = int'($urandom_range(65535, shadow_cfg.max_length + 1));
			push_header(s, b, len);
			repeat ($urandom_range(3))
				s = {s, random_byte_except(shadow_cfg.sync_first)};
		end else begin
			lim = int'(shadow_cfg.max_length);
			if ($urandom_range(99) < 4)
				len = (lim < 300) ? lim : 300;
			else
				len = int'($urandom_range((lim < 12) ? lim : 12, 0));
			b = BYTE_W'($urandom);
			push_header(s, b, len);
			sum = '0;
			repeat (len) begin
				b   = BYTE_W'($urandom);
				sum = sum + b;
				s   = {s, b};
			end
			if ($urandom_range(99) < 20)
				sum = sum ^ LEN_W'($urandom_range(65535, 1));
			s = {s, sum[15:8]};
			s = {s, sum[7:0]};
		end
		send_stream(s);
	endtask

	task automatic test_directed_frames();
		byte_queue_t s;
		s = '{8'hAA, 8'h55, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h00, 8'hFF};
		send_stream(s);
		// empty payload, checksum off by one
		s = '{8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
		send_stream(s);
		// second sync wrong; that byte is not retried as a first sync
		s = '{8'hAA, 8'hAA, 8'h55};
		send_stream(s);
		// one past the limit, trailing byte ignored
		s = '{8'hAA, 8'h55, 8'h07, 8'h01, 8'h01, 8'h12};
		send_stream(s);
		wait_idle();
	endtask

	task automatic test_register_writes();
		byte_queue_t s;
		s = '{8'hAA, 8'h55, 8'h3C, 8'h00};
		send_stream(s);
		write_reg(REG_MAX_LENGTH, 16'd3);
		s = '{8'h04};
		send_stream(s);
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_MAX_LENGTH, 16'hFFFE);
		s = '{8'hAA, 8'h55, 8'hC3, 8'hFF, 8'hFF};
		send_stream(s);
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST);
	endtask

	task automatic test_backpressure();
		byte_queue_t       s;
		logic [LEN_W-1:0]  sum;
		logic [BYTE_W-1:0] b;
		sum = '0;
		hold_requests++;
		push_header(s, 8'h5A, 200);
		repeat (200) begin
			b   = BYTE_W'($urandom);
			sum = sum + b;
			s   = {s, b};
		end
		s = {s, sum[15:8]};
		s = {s, sum[7:0]};
		send_stream(s);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int start;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					set_config(8'h00, 8'hFF, 16'h0000);
				end
				1: begin
					idle_pct  = 53;
					stall_pct = 0;
					set_config(8'hFF, 8'h00, 16'hFFFF);
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 53;
					set_config(BYTE_W'($urandom), BYTE_W'($urandom),
						LEN_W'($urandom_range(64, 1)));
				end
				default: begin
					idle_pct  = 23;
					stall_pct = 23;
					set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST);
				end
			endcase
			start = framed_bytes;
			while (framed_bytes - start < PHASE_BYTES)
				send_random_frame();
		end
		wait_idle();
	endtask

	initial begin : receiver
		int held;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_delivery
		delivery_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_deliveries.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected request: byte %02h type %02h end %0d status %0d",
						payload_byte, frame_type, frame_end, frame_status);
			end else begin
				want = expected_deliveries.pop_front();
				if (want.data !== payload_byte || want.ftype !== frame_type ||
						want.last !== frame_end || want.status !== frame_status) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"mismatch: expected byte %02h type %02h end %0d status %0d,",
							" got byte %02h type %02h end %0d status %0d"},
							want.data, want.ftype, want.last, want.status,
							payload_byte, frame_type, frame_end, frame_status);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = '0;
		wr_data       = '0;
		in_valid      = 1'b0;
		in_byte       = '0;
		shadow_cfg    = {SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST};
		frame_phase   = PH_HUNT;
		cur_type      = '0;
		sum_high      = '0;
		frame_len     = '0;
		payload_count = '0;
		payload_sum   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_register_writes();
		test_backpressure();
		test_random_traffic();
		$display("Run fed %0d in-frame bytes: %0d payload bytes, %0d good,",
			framed_bytes, payload_total, ends_ok);
		$display("%0d bad-sum, %0d too-long ends; limits 0 to 65535, sync 00/FF, four idling mixes.",
			ends_bad, ends_long);
		if (mismatch_count == 0 && expected_deliveries.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
